// ----- hw/rtl/wls_pkg.sv -----
// Shared constants and helper functions for the wear-leveled record store.
`default_nettype none

package wls_pkg;

  // Store geometry
  localparam int STORE_BYTES_DEF = 512;
  localparam int REC_BYTES       = 4;

  // Byte and value limits
  localparam logic [7:0]  ERASED    = 8'hFF;
  localparam logic [13:0] MAX_VALUE = 14'd9999;

  // One BCD byte to binary, nibble by nibble (malformed bytes give up to 165)
  function automatic logic [7:0] bcd_byte_to_bin(input logic [7:0] b);
    logic [7:0] tens;
    tens = 8'(b[7:4]) * 8'd10;
    return tens + 8'(b[3:0]);
  endfunction

  // One double-dabble step: add 3 to each digit of 5 or more, then shift left
  function automatic logic [29:0] dd_step(input logic [29:0] acc);
    logic [29:0] adj;
    adj = acc;
    for (int i = 0; i < 4; i++) begin
      if (acc[14 + 4*i +: 4] >= 4'd5) begin
        adj[14 + 4*i +: 4] = acc[14 + 4*i +: 4] + 4'd3;
      end
    end
    return {adj[28:0], 1'b0};
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/wear_leveled_record_store.sv -----
// Top level: circular record log in a byte-lane memory, scanned by a small sequencer.
// Reset runs a clearing pass over all STORE_BYTES/4 records (one record a cycle); busy is high meanwhile.
// Read: a scan of the records up to the marker (1 .. STORE_BYTES/4 of them), each through the
// registered memory read port, then a read and decode of the record before the marker, then done.
// Write: the same scan and read, two 14-step BCD conversions on one shared unit, then the record
// write and, if a next record exists, the marker write. One item at a time; the receiver cannot stall.
`default_nettype none

module wear_leveled_record_store #(
  parameter int STORE_BYTES = wls_pkg::STORE_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        operation,
  input  wire logic        slot,
  input  wire logic [13:0] value,
  output logic             done,
  output logic [13:0]      stored_value
);

  localparam int REC_COUNT = STORE_BYTES / wls_pkg::REC_BYTES;
  localparam int ROW_W     = $clog2(REC_COUNT);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(REC_COUNT - 1);

  // Sequencer states
  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_SCAN_WAIT = 4'd2;
  localparam logic [3:0] S_SCAN_CHK  = 4'd3;
  localparam logic [3:0] S_RD_WAIT   = 4'd4;
  localparam logic [3:0] S_RD_CHK    = 4'd5;
  localparam logic [3:0] S_DEC       = 4'd6;
  localparam logic [3:0] S_CONV_NEW  = 4'd7;
  localparam logic [3:0] S_CONV_OTH  = 4'd8;
  localparam logic [3:0] S_WR_REC    = 4'd9;
  localparam logic [3:0] S_WR_MARK   = 4'd10;

  localparam logic [3:0] DD_LAST = 4'd13;

  // Record memory, four byte lanes per row
  logic [3:0][7:0] mem [REC_COUNT];
  logic [3:0][7:0] rdata;
  logic            mem_we;
  logic [3:0]      mem_be;
  logic [3:0][7:0] mem_wdata;

  logic [3:0]       state;
  logic [ROW_W-1:0] ptr;
  logic             op;
  logic             sel;
  logic [13:0]      val_sat;
  logic [ROW_W-1:0] mark_idx;
  logic             slot_erased;
  logic [7:0]       hi_bin;
  logic [7:0]       lo_bin;
  logic [13:0]      other_val;
  logic [15:0]      dd_bcd;
  logic [13:0]      dd_bin;
  logic [3:0]       dd_cnt;
  logic [15:0]      bcd_new;

  logic             rd_slot;
  logic [7:0]       rd_hi;
  logic [7:0]       rd_lo;
  logic [14:0]      dec_sum;
  logic [13:0]      dec_val;
  logic [29:0]      dd_next;

  assign busy = (state != S_IDLE);

  // Slot picked from the current record: the other slot on a write
  assign rd_slot = op ? ~sel : sel;
  assign rd_hi   = rdata[{rd_slot, 1'b0}];
  assign rd_lo   = rdata[{rd_slot, 1'b1}];

  // Decode of the registered byte values, saturated
  assign dec_sum = 15'(hi_bin) * 15'd100 + 15'(lo_bin);
  always_comb begin
    if (slot_erased) begin
      dec_val = '0;
    end else if (dec_sum > 15'(wls_pkg::MAX_VALUE)) begin
      dec_val = wls_pkg::MAX_VALUE;
    end else begin
      dec_val = dec_sum[13:0];
    end
  end

  // Shared binary-to-BCD step
  assign dd_next = wls_pkg::dd_step({dd_bcd, dd_bin});

  // Memory write controls
  always_comb begin
    mem_we    = 1'b0;
    mem_be    = 4'b0000;
    mem_wdata = '0;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_be    = 4'b1111;
        mem_wdata = {4{wls_pkg::ERASED}};
      end
      S_WR_REC: begin
        mem_we = 1'b1;
        mem_be = 4'b1111;
        if (sel) begin
          mem_wdata = {bcd_new[7:0], bcd_new[15:8], dd_bcd[7:0], dd_bcd[15:8]};
        end else begin
          mem_wdata = {dd_bcd[7:0], dd_bcd[15:8], bcd_new[7:0], bcd_new[15:8]};
        end
      end
      S_WR_MARK: begin
        mem_we       = 1'b1;
        mem_be       = 4'b0001;
        mem_wdata[0] = wls_pkg::ERASED;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Memory: byte-lane write and registered read at the shared row pointer
  always_ff @(posedge clk) begin
    if (mem_we) begin
      for (int i = 0; i < 4; i++) begin
        if (mem_be[i]) begin
          mem[ptr][i] <= mem_wdata[i];
        end
      end
    end
    rdata <= mem[ptr];
  end

  // Result strobe at the end of each item
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ((state == S_DEC) && !op) || (state == S_WR_MARK) ||
              ((state == S_WR_REC) && (ptr == LAST_ROW));
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ptr   <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (ptr == LAST_ROW) begin
            ptr   <= '0;
            state <= S_IDLE;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            op      <= operation;
            sel     <= slot;
            val_sat <= (value > wls_pkg::MAX_VALUE) ? wls_pkg::MAX_VALUE : value;
            ptr     <= '0;
            state   <= S_SCAN_WAIT;
          end
        end
        S_SCAN_WAIT: begin
          state <= S_SCAN_CHK;
        end
        // Look for the first record that starts erased
        S_SCAN_CHK: begin
          if (rdata[0] == wls_pkg::ERASED) begin
            mark_idx <= ptr;
            ptr      <= (ptr == '0) ? LAST_ROW : ptr - 1'b1;
            state    <= S_RD_WAIT;
          end else if (ptr == LAST_ROW) begin
            mark_idx <= '0;
            state    <= S_RD_WAIT;
          end else begin
            ptr   <= ptr + 1'b1;
            state <= S_SCAN_WAIT;
          end
        end
        S_RD_WAIT: begin
          state <= S_RD_CHK;
        end
        S_RD_CHK: begin
          slot_erased <= (rd_hi == wls_pkg::ERASED) && (rd_lo == wls_pkg::ERASED);
          hi_bin      <= wls_pkg::bcd_byte_to_bin(rd_hi);
          lo_bin      <= wls_pkg::bcd_byte_to_bin(rd_lo);
          state       <= S_DEC;
        end
        S_DEC: begin
          if (!op) begin
            stored_value <= dec_val;
            state        <= S_IDLE;
          end else begin
            other_val <= dec_val;
            dd_bin    <= val_sat;
            dd_bcd    <= '0;
            dd_cnt    <= '0;
            state     <= S_CONV_NEW;
          end
        end
        // Convert the new value, then the other slot's value
        S_CONV_NEW: begin
          if (dd_cnt == DD_LAST) begin
            bcd_new <= dd_next[29:14];
            dd_bin  <= other_val;
            dd_bcd  <= '0;
            dd_cnt  <= '0;
            state   <= S_CONV_OTH;
          end else begin
            {dd_bcd, dd_bin} <= dd_next;
            dd_cnt           <= dd_cnt + 1'b1;
          end
        end
        S_CONV_OTH: begin
          {dd_bcd, dd_bin} <= dd_next;
          if (dd_cnt == DD_LAST) begin
            ptr   <= mark_idx;
            state <= S_WR_REC;
          end else begin
            dd_cnt <= dd_cnt + 1'b1;
          end
        end
        // Append the record, then move the marker if a next record exists
        S_WR_REC: begin
          if (ptr == LAST_ROW) begin
            stored_value <= '0;
            state        <= S_IDLE;
          end else begin
            ptr   <= ptr + 1'b1;
            state <= S_WR_MARK;
          end
        end
        S_WR_MARK: begin
          stored_value <= '0;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/wls_checker.sv -----
// Port-level checker for the record store, bound to the top level.
`default_nettype none

module wls_port_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [13:0] stored_value
);

  // Reset starts the clearing pass
  a_reset_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low after reset");

  // An accepted item keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low after accepting an item");

  // A result ends a busy period
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("result strobe outside the end of an item");

  // Strobes are single cycles
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  // Results stay in the decimal range
  a_value_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (stored_value <= wls_pkg::MAX_VALUE))
    else $error("result value out of range");

endmodule

bind wear_leveled_record_store wls_port_checker u_wls_port_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .stored_value (stored_value)
);

`default_nettype wire

// ----- dv/wls_tb_pkg.sv -----
// Operation codes shared by the record store checker and testbench top.
package wls_tb_pkg;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } wls_op_t;

endpackage

// ----- dv/wls_checker.sv -----
// Checker for the record store: mirrors the record log, predicts each result and compares.
module wls_checker #(
  parameter int STORE_BYTES = wls_pkg::STORE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        operation,
  input  logic        slot,
  input  logic [13:0] value,
  input  logic        done,
  input  logic [13:0] stored_value,
  output int          fail_count,
  output int          pending_count
);

  localparam int REC_COUNT = STORE_BYTES / wls_pkg::REC_BYTES;

  // mirrored byte store and the values still owed by the block
  logic [7:0]  log_bytes [STORE_BYTES];
  logic [13:0] owed_values [$];
  logic [13:0] owed;
  int          mismatches = 0;

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic int unsigned byte_to_dec(input logic [7:0] b);
    return int'(b[7:4]) * 10 + int'(b[3:0]);
  endfunction

  function automatic logic [7:0] dec_to_byte(input int unsigned d);
    return {4'(d / 10), 4'(d % 10)};
  endfunction

  // index of the first record starting with an erased byte, REC_COUNT if none
  function automatic int unsigned free_record();
    for (int k = 0; k < REC_COUNT; k++) begin
      if (log_bytes[k * wls_pkg::REC_BYTES] == wls_pkg::ERASED) return k;
    end
    return REC_COUNT;
  endfunction

  // current value of one slot, taken from the record before the free one
  function automatic logic [13:0] slot_value(input logic s);
    int unsigned k;
    int unsigned cur;
    int unsigned base;
    int unsigned v;
    k = free_record();
    cur = (k == 0 || k >= REC_COUNT) ? REC_COUNT - 1 : k - 1;
    base = cur * wls_pkg::REC_BYTES + (s ? 2 : 0);
    if (log_bytes[base] == wls_pkg::ERASED && log_bytes[base + 1] == wls_pkg::ERASED) begin
      return '0;
    end
    v = byte_to_dec(log_bytes[base]) * 100 + byte_to_dec(log_bytes[base + 1]);
    return (v > wls_pkg::MAX_VALUE) ? wls_pkg::MAX_VALUE : 14'(v);
  endfunction

  // append a record carrying the new value and the other slot's current value
  task automatic append_record(input logic s, input logic [13:0] v);
    int unsigned other;
    int unsigned k;
    int unsigned nv;
    int unsigned base;
    other = slot_value(!s);
    k = free_record();
    if (k >= REC_COUNT) k = 0;
    nv = (v > wls_pkg::MAX_VALUE) ? wls_pkg::MAX_VALUE : v;
    base = k * wls_pkg::REC_BYTES;
    log_bytes[base + (s ? 2 : 0)]     = dec_to_byte(nv / 100);
    log_bytes[base + (s ? 2 : 0) + 1] = dec_to_byte(nv % 100);
    log_bytes[base + (s ? 0 : 2)]     = dec_to_byte(other / 100);
    log_bytes[base + (s ? 0 : 2) + 1] = dec_to_byte(other % 100);
    if (k + 1 < REC_COUNT) log_bytes[(k + 1) * wls_pkg::REC_BYTES] = wls_pkg::ERASED;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STORE_BYTES; i++) log_bytes[i] = wls_pkg::ERASED;
      owed_values.delete();
    end else begin
      // results first: a strobe at this edge belongs to an earlier item
      if (done) begin
        if (owed_values.size() == 0) begin
          report_mismatch($sformatf("stored_value %0d with no item outstanding",
                                    stored_value));
        end else begin
          owed = owed_values.pop_front();
          if (stored_value !== owed) begin
            report_mismatch($sformatf("stored_value %0d, predicted %0d",
                                      stored_value, owed));
          end
        end
      end
      // accepted item
      if (start && !busy) begin
        if (operation == wls_tb_pkg::OP_WRITE) begin
          append_record(slot, value);
          owed_values.push_back('0);
        end else begin
          owed_values.push_back(slot_value(slot));
        end
      end
    end
    fail_count    <= mismatches;
    pending_count <= owed_values.size();
  end

endmodule

// ----- dv/testbench.sv -----
// Testbench top for the record store: stimulus, watchdog and final verdict.
module testbench;

  localparam int STORE_BYTES   = wls_pkg::STORE_BYTES_DEF;
  localparam int RANDOM_ITEMS  = 1000;
  // longest access is a write after a full scan of the log
  localparam int DRAIN_CYCLES  = 2 * (STORE_BYTES / 4) + 64;
  localparam int CYCLE_LIMIT   = 2_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        operation = 1'b0;
  logic        slot = 1'b0;
  logic [13:0] value = '0;
  logic        busy;
  logic        done;
  logic [13:0] stored_value;
  int          fail_count;
  int          pending_count;
  int          cycle_count = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  wear_leveled_record_store #(.STORE_BYTES(STORE_BYTES)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .slot(slot), .value(value),
    .done(done), .stored_value(stored_value)
  );

  wls_checker #(.STORE_BYTES(STORE_BYTES)) checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .slot(slot), .value(value),
    .done(done), .stored_value(stored_value),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // present one item and hold it until the block takes it; start stays high
  task automatic send_item(input wls_tb_pkg::wls_op_t op, input logic s,
                           input logic [13:0] v);
    start     <= 1'b1;
    operation <= op;
    slot      <= s;
    value     <= v;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // mostly legal values, some edges, some above the saturation point
  function automatic logic [13:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 14'd9999 : 14'd0;
      1:       return 14'($urandom_range(10000, 16383));
      default: return 14'($urandom_range(0, 9999));
    endcase
  endfunction

  initial begin : stimulus
    int                  issued;
    int                  burst;
    wls_tb_pkg::wls_op_t op;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: fresh store, erased slot, extremes, saturation
    send_item(wls_tb_pkg::OP_READ,  1'b0, 14'd0);
    send_item(wls_tb_pkg::OP_READ,  1'b1, 14'h3FFF);
    send_item(wls_tb_pkg::OP_WRITE, 1'b0, 14'd0);
    send_item(wls_tb_pkg::OP_READ,  1'b0, 14'd0);
    send_item(wls_tb_pkg::OP_READ,  1'b1, 14'd0);
    send_item(wls_tb_pkg::OP_WRITE, 1'b1, 14'd9999);
    send_item(wls_tb_pkg::OP_READ,  1'b1, 14'd0);
    send_item(wls_tb_pkg::OP_READ,  1'b0, 14'd0);
    send_item(wls_tb_pkg::OP_WRITE, 1'b0, 14'h3FFF);
    send_item(wls_tb_pkg::OP_READ,  1'b0, 14'd0);
    send_item(wls_tb_pkg::OP_WRITE, 1'b1, 14'd10000);
    send_item(wls_tb_pkg::OP_READ,  1'b1, 14'd0);
    send_item(wls_tb_pkg::OP_WRITE, 1'b0, 14'd1234);
    pause(3);
    send_item(wls_tb_pkg::OP_WRITE, 1'b1, 14'd5678);
    send_item(wls_tb_pkg::OP_READ,  1'b0, 14'd0);
    send_item(wls_tb_pkg::OP_READ,  1'b1, 14'd0);
    send_item(wls_tb_pkg::OP_WRITE, 1'b0, 14'h2AAA);
    send_item(wls_tb_pkg::OP_WRITE, 1'b1, 14'h1555);
    send_item(wls_tb_pkg::OP_READ,  1'b0, 14'h2AAA);
    send_item(wls_tb_pkg::OP_READ,  1'b1, 14'h1555);
    send_item(wls_tb_pkg::OP_WRITE, 1'b0, 14'd1);
    send_item(wls_tb_pkg::OP_READ,  1'b0, 14'd0);

    // random bursts; write-heavy so the log wraps several times
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 16);
      for (int i = 0; i < burst; i++) begin
        op = ($urandom_range(0, 99) < 55) ? wls_tb_pkg::OP_WRITE : wls_tb_pkg::OP_READ;
        send_item(op, 1'($urandom_range(0, 1)), pick_value());
        issued++;
      end
      // gaps: none, short, or long enough to land anywhere in an access
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 9) == 0) pause($urandom_range(1, 350));
        else pause($urandom_range(1, 20));
      end
    end
    start <= 1'b0;

    // drain
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/wls_pkg.sv
hw/rtl/wear_leveled_record_store.sv
hw/rtl/wls_checker.sv
dv/wls_tb_pkg.sv
dv/wls_checker.sv
dv/testbench.sv
